>>> sv/spt_pkg.sv
// ----------------------------------------------------------------------------
// Spectral peak tracker package
// Shared types, command and register codes, and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package spt_pkg;

	localparam int BINS_DEFAULT = 64;

	localparam logic [1:0] CMD_BIN   = 2'd0;
	localparam logic [1:0] CMD_EOF   = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] REG_AMP_THRESHOLD   = 2'd0;
	localparam logic [1:0] REG_MIN_KEEP_FRAMES = 2'd1;
	localparam logic [1:0] REG_MIN_BIN         = 2'd2;
	localparam logic [1:0] REG_MAX_BIN         = 2'd3;

	localparam logic [15:0] AMP_THRESHOLD_RST   = 16'd80;
	localparam logic [23:0] MIN_KEEP_FRAMES_RST = 24'd0;
	localparam logic [5:0]  MIN_BIN_RST         = 6'd0;
	localparam logic [5:0]  MAX_BIN_RST         = 6'd63;

	localparam logic [23:0] KEEP_MAX = 24'hFF_FFFF;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [5:0]  bin_index;
		logic [15:0] magnitude;
	} in_t;

	typedef struct packed {
		logic [5:0]  track_bin;
		logic [15:0] track_amplitude;
		logic [23:0] start_frame;
		logic [23:0] keep_frames;
		logic        qualified;
		logic        last_of_run;
	} out_t;

	// One track slot as it travels along the cell row.
	typedef struct packed {
		logic        active;
		logic [15:0] amplitude;
		logic [23:0] start;
		logic [23:0] keep;
		logic [23:0] last_match;
	} slot_t;

	// A bin hit broadcast to every cell.
	typedef struct packed {
		logic        hit;
		logic [5:0]  bin;
		logic [15:0] mag;
		logic [23:0] frame;
	} upd_t;

endpackage

`default_nettype wire

>>> sv/spectral_peak_track_tracker_top.sv
// ----------------------------------------------------------------------------
// Spectral peak tracker top level
// Row of per-bin track cells with a rotating retire walk and output staging.
// ----------------------------------------------------------------------------
// Bin beats are taken one per cycle while no retire walk runs. An end-of-frame
// beat in a frame that had a hit, and every flush beat, start a retire walk:
// the cell row rotates one slot per cycle past the head cell unless a retired
// track waits on a stalled output side. An end-of-frame beat in a frame
// without hits only advances the frame counter. Retired tracks come out in
// bin order and the last one of a walk carries last_of_run. Configuration
// may be written whenever the block is idle.
`default_nettype none

module spectral_peak_track_tracker_top #(
	parameter int BINS = spt_pkg::BINS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire spt_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output spt_pkg::out_t      out_data,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [23:0]   cfg_data
);

	localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
	localparam logic [BIN_W-1:0] CNT_LAST = BIN_W'(BINS - 1);

	typedef enum logic [1:0] {IDLE, WALK, DRAIN} state_t;

	state_t           state_q;
	logic [BIN_W-1:0] cnt_q;
	logic [23:0]      frame_q;
	logic             hit_q;
	logic             walk_all_q;
	logic [15:0]      thr_q;
	logic [23:0]      min_keep_q;
	logic [5:0]       min_bin_q;
	logic [5:0]       max_bin_q;
	logic             pend_valid_q;
	spt_pkg::out_t    pend_q;
	logic             out_valid_q;
	spt_pkg::out_t    out_q;

	spt_pkg::upd_t    upd;
	spt_pkg::slot_t   cells [BINS];
	spt_pkg::slot_t   tail;
	spt_pkg::slot_t   head;
	spt_pkg::out_t    pend_last;
	logic             in_acc;
	logic             bin_hit;
	logic             out_free;
	logic [23:0]      age;
	logic             retire_head;
	logic             step;
	logic             load_walk;
	logic             load_drain;
	logic [5:0]       head_bin;
	logic             head_qual;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != IDLE);

	assign bin_hit = in_acc && (in_data.cmd == spt_pkg::CMD_BIN)
	                 && ({1'b0, in_data.bin_index} < 7'(BINS))
	                 && (in_data.magnitude >= thr_q);

	assign upd = '{hit: bin_hit, bin: in_data.bin_index, mag: in_data.magnitude,
	               frame: frame_q};

	// The head cell holds the slot of bin cnt_q while the row rotates.
	assign head        = cells[0];
	assign head_bin    = 6'(cnt_q);
	assign age         = frame_q - head.last_match;
	assign retire_head = head.active && (walk_all_q || (age >= 24'd2));
	assign head_qual   = (head.keep >= min_keep_q) && (head_bin >= min_bin_q)
	                     && (head_bin <= max_bin_q);

	assign out_free   = !out_valid_q || !out_stall;
	assign step       = (state_q == WALK) && (!retire_head || !pend_valid_q || out_free);
	assign load_walk  = step && retire_head && pend_valid_q;
	assign load_drain = (state_q == DRAIN) && pend_valid_q && out_free;

	always_comb begin
		tail = head;
		if (retire_head) begin
			tail.active = 1'b0;
		end
	end

	always_comb begin
		pend_last             = pend_q;
		pend_last.last_of_run = 1'b1;
	end

	for (genvar i = 0; i < BINS; i++) begin : g_cell
		spt_pkg::slot_t nxt;
		if (i == BINS - 1) begin : g_tail
			assign nxt = tail;
		end else begin : g_mid
			assign nxt = cells[i + 1];
		end
		spt_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.upd      (upd),
			.shift    (step),
			.shift_in (nxt),
			.slot     (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= spt_pkg::AMP_THRESHOLD_RST;
			min_keep_q <= spt_pkg::MIN_KEEP_FRAMES_RST;
			min_bin_q  <= spt_pkg::MIN_BIN_RST;
			max_bin_q  <= spt_pkg::MAX_BIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				spt_pkg::REG_AMP_THRESHOLD:   thr_q      <= cfg_data[15:0];
				spt_pkg::REG_MIN_KEEP_FRAMES: min_keep_q <= cfg_data;
				spt_pkg::REG_MIN_BIN:         min_bin_q  <= cfg_data[5:0];
				spt_pkg::REG_MAX_BIN:         max_bin_q  <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			cnt_q        <= '0;
			frame_q      <= 24'd0;
			hit_q        <= 1'b0;
			walk_all_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (load_walk || load_drain) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (bin_hit) begin
						hit_q <= 1'b1;
					end
					if (in_acc) begin
						unique case (in_data.cmd)
							spt_pkg::CMD_EOF: begin
								hit_q <= 1'b0;
								if (hit_q) begin
									walk_all_q <= 1'b0;
									cnt_q      <= '0;
									state_q    <= WALK;
								end else begin
									frame_q <= frame_q + 24'd1;
								end
							end
							spt_pkg::CMD_FLUSH: begin
								walk_all_q <= 1'b1;
								cnt_q      <= '0;
								state_q    <= WALK;
							end
							default: ;
						endcase
					end
				end
				WALK: begin
					if (step) begin
						if (retire_head) begin
							pend_valid_q <= 1'b1;
						end
						if (cnt_q == CNT_LAST) begin
							cnt_q   <= '0;
							state_q <= DRAIN;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				DRAIN: begin
					if (!pend_valid_q || out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= IDLE;
						if (!walk_all_q) begin
							frame_q <= frame_q + 24'd1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step && retire_head) begin
			pend_q <= '{track_bin: head_bin, track_amplitude: head.amplitude,
			            start_frame: head.start, keep_frames: head.keep,
			            qualified: head_qual, last_of_run: 1'b0};
		end
		if (load_walk) begin
			out_q <= pend_q;
		end else if (load_drain) begin
			out_q <= pend_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

>>> sv/spt_cell.sv
// ----------------------------------------------------------------------------
// Spectral peak tracker cell
// Holds the track slot of one bin; starts or extends it on a hit and passes
// its contents to the neighbor while the row rotates.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_cell #(
	parameter int IDX = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire spt_pkg::upd_t  upd,
	input  wire logic           shift,
	input  wire spt_pkg::slot_t shift_in,
	output spt_pkg::slot_t      slot
);

	logic                  active_q;
	logic [15:0]           amp_q;
	logic [23:0]           start_q;
	logic [23:0]           keep_q;
	logic [23:0]           last_q;
	logic                  match;

	assign match = upd.hit && (upd.bin == 6'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (shift) begin
			active_q <= shift_in.active;
		end else if (match) begin
			active_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			amp_q   <= shift_in.amplitude;
			start_q <= shift_in.start;
			keep_q  <= shift_in.keep;
			last_q  <= shift_in.last_match;
		end else if (match) begin
			last_q <= upd.frame;
			if (active_q) begin
				if (keep_q != spt_pkg::KEEP_MAX) begin
					keep_q <= keep_q + 24'd1;
				end
			end else begin
				amp_q   <= upd.mag;
				start_q <= upd.frame;
				keep_q  <= 24'd0;
			end
		end
	end

	assign slot = '{active: active_q, amplitude: amp_q, start: start_q,
	                keep: keep_q, last_match: last_q};

endmodule

`default_nettype wire

>>> sv/spt_checker.sv
// ----------------------------------------------------------------------------
// Spectral peak tracker checker
// Port-level properties of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spt_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          in_valid,
	input wire logic          in_stall,
	input wire spt_pkg::in_t  in_data,
	input wire logic          out_valid,
	input wire logic          out_stall,
	input wire spt_pkg::out_t out_data
);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	// Bin beats never start a walk.
	a_bin_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.cmd == spt_pkg::CMD_BIN) |=> !in_stall)
		else $error("bin beat stalled the input");

	// A flush always walks the row.
	a_flush_walks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.cmd == spt_pkg::CMD_FLUSH) |=> in_stall)
		else $error("flush did not start a walk");

	// Once the block is idle again, any result still shown closes its run.
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_stall |-> out_data.last_of_run)
		else $error("idle with a result that is not last of run");

endmodule

bind spectral_peak_track_tracker_top spt_checker u_spt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectral peak tracker testbench
// Streams bin, end-of-frame and flush beats into the tracker and holds its own
// model of the per-bin track slots and the frame counter. Every retired
// track that comes out is checked field by field against the oldest predicted
// track. Both sides idle at random, and the register settings change between
// phases.
// ----------------------------------------------------------------------------

module tb;

	localparam int NBINS = spt_pkg::BINS_DEFAULT;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = NBINS + 16;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          in_valid = 1'b0;
	logic          in_stall;
	spt_pkg::in_t  in_data = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	spt_pkg::out_t out_data;
	logic          cfg_we = 1'b0;
	logic [1:0]    cfg_index = '0;
	logic [23:0]   cfg_data = '0;

	// Model of the tracker: configuration, slots and frame state.
	logic [15:0] thr;
	logic [23:0] keep_min;
	logic [5:0]  lo_bin;
	logic [5:0]  hi_bin;
	logic        slot_on [NBINS];
	logic [15:0] slot_amp [NBINS];
	logic [23:0] slot_first [NBINS];
	logic [23:0] slot_hits [NBINS];
	logic [23:0] slot_seen [NBINS];
	logic [23:0] frame_no;
	logic        hit_seen;

	spt_pkg::out_t track_q [$];

	bit idle_on = 1'b1;
	int stall_left = 0;
	int beats_sent = 0;
	int beats_used = 0;
	int tracks_checked = 0;
	int settings_used = 0;
	int mismatches = 0;
	int cycles = 0;

	spectral_peak_track_tracker_top #(
		.BINS(NBINS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	// Output stalls come in random bursts while idling is enabled.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 3);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("tb: track %0d %s expected %0h got %0h", tracks_checked, name,
					want, got);
		end
	endtask

	always @(posedge clk) begin
		spt_pkg::out_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (track_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected track beat, bin %0d", out_data.track_bin);
			end else begin
				want = track_q.pop_front();
				check_field("track_bin", 24'(want.track_bin),
					24'(out_data.track_bin));
				check_field("track_amplitude", 24'(want.track_amplitude),
					24'(out_data.track_amplitude));
				check_field("start_frame", want.start_frame, out_data.start_frame);
				check_field("keep_frames", want.keep_frames, out_data.keep_frames);
				check_field("qualified", 24'(want.qualified),
					24'(out_data.qualified));
				check_field("last_of_run", 24'(want.last_of_run),
					24'(out_data.last_of_run));
			end
			tracks_checked++;
		end
	end

	task automatic retire_tracks(input logic sweep_all);
		logic [NBINS-1:0] due;
		logic [23:0] age;
		spt_pkg::out_t t;
		int last;
		due = '0;
		last = -1;
		for (int b = 0; b < NBINS; b++) begin
			age = frame_no - slot_seen[b];
			if (slot_on[b] && (sweep_all || age >= 24'd2)) begin
				due[b] = 1'b1;
				last = b;
			end
		end
		for (int b = 0; b < NBINS; b++) begin
			if (due[b]) begin
				t.track_bin = b[5:0];
				t.track_amplitude = slot_amp[b];
				t.start_frame = slot_first[b];
				t.keep_frames = slot_hits[b];
				t.qualified = slot_hits[b] >= keep_min && b[5:0] >= lo_bin &&
					b[5:0] <= hi_bin;
				t.last_of_run = (b == last);
				track_q = {track_q, t};
				slot_on[b] = 1'b0;
			end
		end
	endtask

	task automatic track_beat(input spt_pkg::in_t beat);
		int b;
		b = int'(beat.bin_index);
		case (beat.cmd)
			spt_pkg::CMD_BIN: begin
				if (b < NBINS && beat.magnitude >= thr) begin
					beats_used++;
					hit_seen = 1'b1;
					if (slot_on[b]) begin
						if (slot_hits[b] != spt_pkg::KEEP_MAX)
							slot_hits[b] = slot_hits[b] + 24'd1;
						slot_seen[b] = frame_no;
					end else begin
						slot_on[b] = 1'b1;
						slot_amp[b] = beat.magnitude;
						slot_first[b] = frame_no;
						slot_hits[b] = '0;
						slot_seen[b] = frame_no;
					end
				end
			end
			spt_pkg::CMD_EOF: begin
				beats_used++;
				if (hit_seen)
					retire_tracks(1'b0);
				hit_seen = 1'b0;
				frame_no = frame_no + 24'd1;
			end
			spt_pkg::CMD_FLUSH: begin
				beats_used++;
				retire_tracks(1'b1);
			end
			default: begin
			end
		endcase
	endtask

	// Called at a rising edge; returns at the edge where the beat was taken.
	task automatic send_beat(input spt_pkg::in_t beat);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		track_beat(beat);
		beats_sent++;
	endtask

	function automatic spt_pkg::in_t bin_beat(input logic [5:0] b,
			input logic [15:0] mag);
		spt_pkg::in_t beat;
		beat.cmd = spt_pkg::CMD_BIN;
		beat.bin_index = b;
		beat.magnitude = mag;
		return beat;
	endfunction

	function automatic spt_pkg::in_t cmd_beat(input logic [1:0] cmd);
		spt_pkg::in_t beat;
		beat.cmd = cmd;
		beat.bin_index = 6'($urandom);
		beat.magnitude = 16'($urandom);
		return beat;
	endfunction

	function automatic logic [15:0] pick_mag(input logic hit);
		if (hit || thr == 16'd0)
			return 16'($urandom_range(int'(thr), 16'hFFFF));
		return 16'($urandom_range(0, int'(thr) - 1));
	endfunction

	// The sender holds off until every predicted track has come out.
	task automatic wait_tracks();
		if (track_q.size() != 0) begin
			in_valid <= 1'b0;
			while (track_q.size() != 0)
				@(posedge clk);
		end
	endtask

	// Leaves the block idle: no track pending and any retire walk finished.
	task automatic drain();
		in_valid <= 1'b0;
		while (track_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			spt_pkg::REG_AMP_THRESHOLD:   thr = val[15:0];
			spt_pkg::REG_MIN_KEEP_FRAMES: keep_min = val;
			spt_pkg::REG_MIN_BIN:         lo_bin = val[5:0];
			spt_pkg::REG_MAX_BIN:         hi_bin = val[5:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_config(input logic [15:0] t, input logic [23:0] k,
			input logic [5:0] lo, input logic [5:0] hi);
		put_reg(spt_pkg::REG_AMP_THRESHOLD, {8'd0, t});
		put_reg(spt_pkg::REG_MIN_KEEP_FRAMES, k);
		put_reg(spt_pkg::REG_MIN_BIN, {18'd0, lo});
		put_reg(spt_pkg::REG_MAX_BIN, {18'd0, hi});
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Frames of hits on a few recurring bins, with flushes, ignored beats and
	// full hold-offs mixed in.
	task automatic run_tracks(input int want);
		logic [5:0] hot_bins [8];
		int goal;
		int pick;
		int nbins;
		logic [5:0] b;
		goal = beats_used + want;
		foreach (hot_bins[i])
			hot_bins[i] = 6'($urandom);
		while (beats_used < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_beat($urandom_range(0, 1) ? cmd_beat(CMD_UNUSED) :
					bin_beat(6'($urandom), pick_mag(1'b0)));
			end else if (pick < 13) begin
				send_beat(cmd_beat(spt_pkg::CMD_FLUSH));
			end else if (pick < 17) begin
				wait_tracks();
			end else begin
				nbins = $urandom_range(0, 5);
				repeat (nbins) begin
					b = $urandom_range(0, 3) == 0 ? 6'($urandom) :
						hot_bins[$urandom_range(0, 7)];
					send_beat(bin_beat(b, pick_mag($urandom_range(0, 7) != 0)));
				end
				send_beat(cmd_beat(spt_pkg::CMD_EOF));
			end
		end
	endtask

	task automatic test_directed();
		send_beat(cmd_beat(spt_pkg::CMD_EOF));
		send_beat(bin_beat(6'd0, 16'd80));
		send_beat(bin_beat(6'd63, 16'hFFFF));
		send_beat(bin_beat(6'd5, 16'd79));
		send_beat(bin_beat(6'd0, 16'd100));
		send_beat(cmd_beat(CMD_UNUSED));
		send_beat(cmd_beat(spt_pkg::CMD_EOF));
		send_beat(bin_beat(6'd63, 16'd200));
		send_beat(cmd_beat(spt_pkg::CMD_EOF));
		send_beat(bin_beat(6'd10, 16'hFFFF));
		send_beat(cmd_beat(spt_pkg::CMD_EOF));
		wait_tracks();
		send_beat(bin_beat(6'd20, 16'd80));
		send_beat(bin_beat(6'h15, 16'hAAAA));
		send_beat(bin_beat(6'h2A, 16'h5555));
		send_beat(cmd_beat(spt_pkg::CMD_EOF));
		send_beat(cmd_beat(spt_pkg::CMD_FLUSH));
		send_beat(cmd_beat(spt_pkg::CMD_FLUSH));
		send_beat(bin_beat(6'd7, 16'd0));
		send_beat(cmd_beat(spt_pkg::CMD_EOF));
		drain();
	endtask

	task automatic test_config_extremes();
		set_config(16'd0, spt_pkg::KEEP_MAX, 6'd63, 6'd0);
		run_tracks(30);
		send_beat(bin_beat(6'd33, 16'd0));
		send_beat(cmd_beat(spt_pkg::CMD_FLUSH));
		drain();
		set_config(16'hFFFF, 24'd0, 6'd0, 6'd63);
		run_tracks(30);
		drain();
	endtask

	task automatic test_random_settings();
		logic [15:0] t;
		logic [23:0] k;
		logic [5:0] lo;
		logic [5:0] hi;
		repeat (4) begin
			t = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1, 2000));
			k = $urandom_range(0, 4) == 0 ? 24'($urandom) : 24'($urandom_range(0, 4));
			lo = 6'($urandom_range(0, 40));
			hi = $urandom_range(0, 4) == 0 ? 6'($urandom) :
				6'($urandom_range(int'(lo), 63));
			set_config(t, k, lo, hi);
			run_tracks(40);
			drain();
		end
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		set_config(16'($urandom_range(1, 1000)), 24'($urandom_range(0, 3)),
			6'($urandom_range(0, 20)), 6'($urandom_range(40, 63)));
		run_tracks(40);
		send_beat(cmd_beat(spt_pkg::CMD_FLUSH));
		drain();
	endtask

	initial begin
		thr = spt_pkg::AMP_THRESHOLD_RST;
		keep_min = spt_pkg::MIN_KEEP_FRAMES_RST;
		lo_bin = spt_pkg::MIN_BIN_RST;
		hi_bin = spt_pkg::MAX_BIN_RST;
		for (int b = 0; b < NBINS; b++) begin
			slot_on[b] = 1'b0;
			slot_amp[b] = '0;
			slot_first[b] = '0;
			slot_hits[b] = '0;
			slot_seen[b] = '0;
		end
		frame_no = '0;
		hit_seen = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_config_extremes();
		test_random_settings();
		test_steady_stream();

		$display("tb: %0d beats sent (%0d not ignored), %0d retired tracks checked",
			beats_sent, beats_used, tracks_checked);
		$display("tb: %0d register settings, %0d frames, %0d mismatches", settings_used,
			frame_no, mismatches);
		if (mismatches == 0 && track_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
sv/spt_pkg.sv
sv/spt_cell.sv
sv/spectral_peak_track_tracker_top.sv
sv/spt_checker.sv
tb/sv/tb.sv
